>>> rtl/core/sme_pkg.sv
package sme_pkg;

  localparam int CAPACITY   = 64;
  localparam int VALUE_BITS = 32;
  localparam int ROW_BITS   = 16;
  localparam int COL_BITS   = 16;
  localparam int KIND_BITS  = 2;
  localparam int SLOT_BITS  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  typedef enum logic [KIND_BITS-1:0] {
    KIND_QUERY  = 2'd0,
    KIND_INSERT = 2'd1,
    KIND_DELETE = 2'd2
  } kind_e;

  localparam logic STATUS_DONE = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  typedef logic [SLOT_BITS-1:0] slot_idx_t;

  typedef struct packed {
    logic                 valid;
    logic [KIND_BITS-1:0] kind;
    logic [ROW_BITS-1:0]  row;
    logic [COL_BITS-1:0]  col;
  } cmd_t;

  typedef struct packed {
    logic      found;
    logic      status;
    logic      wr_en;
    slot_idx_t wr_idx;
    slot_idx_t hit_idx;
  } lookup_t;

endpackage

>>> rtl/core/sme_if.sv
interface sme_req_if import sme_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic [KIND_BITS-1:0]         kind;
  logic [ROW_BITS-1:0]          row_index;
  logic [COL_BITS-1:0]          col_index;
  logic signed [VALUE_BITS-1:0] entry_value;

  modport source (output valid, kind, row_index, col_index, entry_value, input ready);
  modport sink   (input valid, kind, row_index, col_index, entry_value, output ready);
endinterface

interface sme_rsp_if ();
  logic valid;
  logic ready;
  logic found;
  logic status;

  modport source (output valid, found, status, input ready);
  modport sink   (input valid, found, status, output ready);
endinterface

>>> rtl/core/sparse_matrix_entry_store.sv
// Channel  Role    Beat payload
// req      sink    kind, row_index, col_index, entry_value
// rsp      source  found, status
//
// One beat on req gives exactly one beat on rsp, via the input and result registers.
// A new req beat can be taken every cycle unless rsp is stalled; the table is updated
// at the edge that registers the result, so each beat sees the effect of the last one.
// Lookup compares all slots of the coordinate table in parallel, combinationally.
// Reset is synchronous and clears every valid mark at once; no clearing pass.
// A stalled rsp holds its beat and backs up into the input register, then into req.
module sparse_matrix_entry_store import sme_pkg::*; (
  input logic    clk,
  input logic    rst,
  sme_req_if.sink  req,
  sme_rsp_if.source rsp
);

  logic                         in_valid;
  logic [KIND_BITS-1:0]         in_kind;
  logic [ROW_BITS-1:0]          in_row;
  logic [COL_BITS-1:0]          in_col;
  logic [VALUE_BITS-1:0]        in_value;
  logic                         res_valid;
  logic                         res_found;
  logic                         res_status;
  logic                         advance;
  cmd_t                         cmd;
  lookup_t                      lookup;
  logic [VALUE_BITS-1:0]        stored_value;

  assign advance   = !res_valid || rsp.ready;
  assign req.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (req.valid && req.ready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      in_kind  <= req.kind;
      in_row   <= req.row_index;
      in_col   <= req.col_index;
      in_value <= req.entry_value;
    end
  end

  always_comb begin
    cmd.valid = in_valid && advance;
    cmd.kind  = in_kind;
    cmd.row   = in_row;
    cmd.col   = in_col;
  end

  sme_cam u_cam (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .lookup (lookup)
  );

  sme_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (CAPACITY)
  ) u_value_ram (
    .clk     (clk),
    .wr_en   (lookup.wr_en),
    .wr_addr (lookup.wr_idx),
    .wr_data (in_value),
    .rd_addr (lookup.hit_idx),
    .rd_data (stored_value)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.valid) begin
      res_valid <= 1'b1;
    end else if (rsp.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid) begin
      res_found  <= lookup.found;
      res_status <= lookup.status;
    end
  end

  assign rsp.valid  = res_valid;
  assign rsp.found  = res_found;
  assign rsp.status = res_status;

  assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.ready) |=>
      (rsp.valid && $stable(rsp.found) && $stable(rsp.status)))
    else $error("stalled response beat changed");

  assert property (@(posedge clk) disable iff (rst)
    (in_valid && !advance) |=>
      (in_valid && $stable(in_kind) && $stable(in_row) && $stable(in_col)))
    else $error("held input beat changed");

  assert property (@(posedge clk) disable iff (rst)
    lookup.wr_en ##1 (lookup.hit_idx == $past(lookup.wr_idx)) |=>
      (stored_value == $past(in_value, 2)))
    else $error("stored value does not read back");

endmodule

>>> rtl/core/sme_ram.sv
module sme_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                         clk,
  input  logic                                         wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                             wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                             rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

>>> rtl/core/sme_cam.sv
module sme_cam import sme_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  cmd_t    cmd,
  output lookup_t lookup
);

  logic [CAPACITY-1:0] slot_valid;
  logic [ROW_BITS-1:0] slot_row [CAPACITY];
  logic [COL_BITS-1:0] slot_col [CAPACITY];

  logic [CAPACITY-1:0] match;
  logic [CAPACITY-1:0] empty;
  logic [CAPACITY-1:0] free_oh;
  logic                hit;
  logic                full;
  slot_idx_t           hit_idx;
  slot_idx_t           free_idx;
  logic                do_insert;
  logic                do_delete;

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      match[i] = slot_valid[i] && (slot_row[i] == cmd.row) && (slot_col[i] == cmd.col);
    end
  end

  assign empty   = ~slot_valid;
  assign free_oh = empty & (~empty + CAPACITY'(1));
  assign hit     = |match;
  assign full    = &slot_valid;

  always_comb begin
    hit_idx  = '0;
    free_idx = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (match[i]) begin
        hit_idx = hit_idx | SLOT_BITS'(i);
      end
      if (free_oh[i]) begin
        free_idx = free_idx | SLOT_BITS'(i);
      end
    end
  end

  assign do_insert = cmd.valid && (cmd.kind == KIND_INSERT);
  assign do_delete = cmd.valid && (cmd.kind == KIND_DELETE);

  always_comb begin
    lookup.found   = hit;
    lookup.status  = (do_insert && !hit && full) ? STATUS_FULL : STATUS_DONE;
    lookup.wr_en   = do_insert && (hit || !full);
    lookup.wr_idx  = hit ? hit_idx : free_idx;
    lookup.hit_idx = hit_idx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
    end else if (do_insert && !hit && !full) begin
      slot_valid[free_idx] <= 1'b1;
    end else if (do_delete && hit) begin
      slot_valid[hit_idx] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_insert && !hit && !full) begin
      slot_row[free_idx] <= cmd.row;
      slot_col[free_idx] <= cmd.col;
    end
  end

  // A coordinate is never stored twice, so at most one slot can match.
  assert property (@(posedge clk) disable iff (rst) $onehot0(match))
    else $error("more than one slot matches the coordinate");

  assert property (@(posedge clk) disable iff (rst)
    (do_delete && hit) |=> !slot_valid[$past(hit_idx)])
    else $error("deleted slot is still marked valid");

  assert property (@(posedge clk) disable iff (rst)
    (do_insert && !hit && !full) |=> slot_valid[$past(free_idx)])
    else $error("inserted slot was not marked valid");

  assert property (@(posedge clk) disable iff (rst)
    (lookup.status == STATUS_FULL) |-> (full && !hit))
    else $error("insert dropped while a slot was free or the coordinate present");

endmodule

>>> verif/sme_entry_tracker.sv
module sme_entry_tracker import sme_pkg::*; (
  input  logic clk,
  input  logic rst,
  sme_req_if   req,
  sme_rsp_if   rsp,
  output int   mismatches,
  output int   pending
);

  typedef struct packed {
    logic found;
    logic status;
  } outcome_t;

  logic                  occupied   [CAPACITY];
  logic [ROW_BITS-1:0]   held_row   [CAPACITY];
  logic [COL_BITS-1:0]   held_col   [CAPACITY];
  logic [VALUE_BITS-1:0] held_value [CAPACITY];
  outcome_t              awaited    [$];
  int                    fail_count;

  function automatic outcome_t apply_op(input logic [KIND_BITS-1:0] kind,
                                        input logic [ROW_BITS-1:0] r,
                                        input logic [COL_BITS-1:0] c,
                                        input logic [VALUE_BITS-1:0] v);
    int       hit;
    int       free_slot;
    outcome_t res;
    hit = -1;
    free_slot = -1;
    res.found = 1'b0;
    res.status = STATUS_DONE;
    for (int i = 0; i < CAPACITY; i++) begin
      if (occupied[i]) begin
        if (hit < 0 && held_row[i] == r && held_col[i] == c) hit = i;
      end else if (free_slot < 0) begin
        free_slot = i;
      end
    end
    res.found = (hit >= 0);
    if (kind == KIND_INSERT) begin
      if (hit >= 0) begin
        held_value[hit] = v;
      end else if (free_slot >= 0) begin
        occupied[free_slot]   = 1'b1;
        held_row[free_slot]   = r;
        held_col[free_slot]   = c;
        held_value[free_slot] = v;
      end else begin
        res.status = STATUS_FULL;
      end
    end else if (kind == KIND_DELETE) begin
      if (hit >= 0) occupied[hit] = 1'b0;
    end
    return res;
  endfunction

  always @(posedge clk) begin
    outcome_t want;
    if (rst) begin
      for (int i = 0; i < CAPACITY; i++) occupied[i] = 1'b0;
      awaited.delete();
      fail_count = 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (awaited.size() == 0) begin
          $error("response beat with nothing outstanding: found=%0b status=%0b",
                 rsp.found, rsp.status);
          fail_count++;
        end else begin
          want = awaited.pop_front();
          if (rsp.found !== want.found) begin
            $error("found mismatch: expected %0b, actual %0b", want.found, rsp.found);
            fail_count++;
          end
          if (rsp.status !== want.status) begin
            $error("status mismatch: expected %0b, actual %0b", want.status, rsp.status);
            fail_count++;
          end
        end
      end
      if (req.valid && req.ready) begin
        awaited.push_back(apply_op(req.kind, req.row_index, req.col_index, req.entry_value));
      end
    end
    mismatches <= fail_count;
    pending    <= awaited.size();
  end

endmodule

>>> verif/sparse_matrix_entry_store_tb.sv
module sparse_matrix_entry_store_tb;
  import sme_pkg::*;

  localparam logic [KIND_BITS-1:0] KIND_UNUSED = 2'd3;
  localparam int POOL_SIZE  = 96;
  localparam int SEG_ITEMS  = 172;
  localparam int IDLE_LIMIT = 1000;

  logic clk;
  logic rst;
  int   idle_pct;
  int   stall_pct;
  int   mismatches;
  int   pending;

  logic [ROW_BITS-1:0] pool_row [POOL_SIZE];
  logic [COL_BITS-1:0] pool_col [POOL_SIZE];

  sme_req_if req_ch ();
  sme_rsp_if rsp_ch ();

  sparse_matrix_entry_store uut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  sme_entry_tracker tracker (
    .clk        (clk),
    .rst        (rst),
    .req        (req_ch),
    .rsp        (rsp_ch),
    .mismatches (mismatches),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  task automatic send_op(input logic [KIND_BITS-1:0] kind,
                         input logic [ROW_BITS-1:0] r,
                         input logic [COL_BITS-1:0] c,
                         input logic [VALUE_BITS-1:0] v);
    while ($urandom_range(99) < idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid       <= 1'b1;
    req_ch.kind        <= kind;
    req_ch.row_index   <= r;
    req_ch.col_index   <= c;
    req_ch.entry_value <= v;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  initial begin
    int                   roll;
    int                   pick;
    logic [KIND_BITS-1:0] kind;
    logic [ROW_BITS-1:0]  r;
    logic [COL_BITS-1:0]  c;
    rst                = 1'b1;
    idle_pct           = 0;
    stall_pct          = 0;
    req_ch.valid       = 1'b0;
    req_ch.kind        = KIND_QUERY;
    req_ch.row_index   = '0;
    req_ch.col_index   = '0;
    req_ch.entry_value = '0;
    pool_row[0] = '0;
    pool_col[0] = '0;
    pool_row[1] = '1;
    pool_col[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) begin
      pool_row[i] = ROW_BITS'($urandom_range(65535));
      pool_col[i] = COL_BITS'($urandom_range(65535));
    end
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    send_op(KIND_QUERY,  16'h0000, 16'h0000, 32'h0000_0000);
    send_op(KIND_INSERT, 16'h0000, 16'h0000, 32'h8000_0000);
    send_op(KIND_QUERY,  16'h0000, 16'h0000, 32'h0000_0000);
    send_op(KIND_INSERT, 16'h0000, 16'h0000, 32'h7FFF_FFFF);
    send_op(KIND_INSERT, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
    send_op(KIND_INSERT, 16'h0000, 16'hFFFF, 32'h0000_0000);
    send_op(KIND_INSERT, 16'hFFFF, 16'h0000, 32'h0000_0001);
    send_op(KIND_QUERY,  16'hFFFF, 16'h0000, 32'hDEAD_BEEF);
    send_op(KIND_UNUSED, 16'hFFFF, 16'hFFFF, 32'h1234_5678);
    send_op(KIND_UNUSED, 16'h0001, 16'h0001, 32'h5555_AAAA);
    send_op(KIND_QUERY,  16'h0001, 16'h0001, 32'h0000_0000);
    send_op(KIND_DELETE, 16'h0001, 16'h0001, 32'hFFFF_FFFF);
    send_op(KIND_DELETE, 16'h0000, 16'h0000, 32'h0000_0000);
    send_op(KIND_QUERY,  16'h0000, 16'h0000, 32'h0000_0000);
    send_op(KIND_DELETE, 16'h0000, 16'h0000, 32'h0000_0000);
    send_op(KIND_INSERT, 16'h0000, 16'h0000, 32'h0000_0005);
    send_op(KIND_QUERY,  16'hFFFF, 16'h0000, 32'h0000_0000);
    send_op(KIND_QUERY,  16'h0000, 16'h0000, 32'h0000_0000);

    // Even segments fill the table past capacity; odd segments drain it again.
    for (int seg = 0; seg < 8; seg++) begin
      case (seg / 2)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 59; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 59; end
        default: begin idle_pct = 33; stall_pct = 33; end
      endcase
      for (int n = 0; n < SEG_ITEMS; n++) begin
        roll = $urandom_range(99);
        if (seg % 2 == 0) begin
          kind = (roll < 70) ? KIND_INSERT : (roll < 85) ? KIND_QUERY : KIND_DELETE;
        end else begin
          kind = (roll < 30) ? KIND_INSERT : (roll < 55) ? KIND_QUERY : KIND_DELETE;
        end
        if ($urandom_range(99) < 90) begin
          pick = $urandom_range(POOL_SIZE - 1);
          r = pool_row[pick];
          c = pool_col[pick];
        end else begin
          r = ROW_BITS'($urandom_range(65535));
          c = COL_BITS'($urandom_range(65535));
        end
        send_op(kind, r, c, $urandom);
      end
    end

    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("Verification failed");
    $finish;
  end

endmodule
